[rtl/tola_pkg.sv]
// Shared types and constants for the ticket ordered lock arbiter.
// Used by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps

package tola_pkg;

   localparam int DEF_MAX_REQUESTERS = 8;
   localparam int DEF_TICKET_BITS    = 32;

   localparam logic [3:0] ACTIVE_COUNT_RESET = 4'd8;

   // action codes, code 3 is unused
   localparam logic [1:0] ACT_REQUEST = 2'd0;
   localparam logic [1:0] ACT_POLL    = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] requester;
   } req_type;

   typedef struct packed {
      logic        granted;
      logic [31:0] ticket;
      logic        ticket_saturated;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic rd_en;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic in_range;
   } status_type;

endpackage

[rtl/ticket_ordered_lock_arbiter.sv]
// Bakery-style lock arbiter: each requester asks for a ticket, polls for the grant and
// releases; one result comes back per request. One comparator walks the first N
// entries of the ticket memory one entry a cycle, N being the active count limited to
// MAX_REQUESTERS. A request passes an accept step, the scan with its registered read,
// and a step that writes back and loads the result register. A requester id outside
// the array goes from the scan state straight to the finish state. A finished result
// waits in the output register while the next request is taken. Per-entry valid bits
// make every ticket read as zero after reset, so there is no clearing pass.
// Depends on tola_pkg, tola_ctrl and tola_dpath.
`timescale 1ns / 1ps

module ticket_ordered_lock_arbiter #(
   parameter int MAX_REQUESTERS = tola_pkg::DEF_MAX_REQUESTERS,
   parameter int TICKET_BITS    = tola_pkg::DEF_TICKET_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tola_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tola_pkg::rsp_type   rsp_data,
   input  logic                csr_we,
   input  logic [3:0]          csr_data
);
   import tola_pkg::*;

   localparam int IDX_BITS = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;

   cmd_type             cmd;
   status_type          status;
   logic [IDX_BITS-1:0] rd_idx;

   tola_ctrl #(
      .MAX_REQUESTERS (MAX_REQUESTERS),
      .IDX_BITS       (IDX_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_we    (csr_we),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .rd_idx    (rd_idx),
      .status    (status)
   );

   tola_dpath #(
      .MAX_REQUESTERS (MAX_REQUESTERS),
      .TICKET_BITS    (TICKET_BITS),
      .IDX_BITS       (IDX_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .rd_idx    (rd_idx),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .status    (status)
   );

`ifndef NO_ASSERTIONS
   // one request in flight: after acceptance the input side stalls
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another was in flight");

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while stalled");

   // a result appears only after the controller finished a request
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.finish))
      else $error("result valid without a finished request");
`endif

endmodule

[rtl/tola_ctrl.sv]
// Sequencer of the arbiter: request handshake, scan counter and config register.
// Depends on tola_pkg; drives the datapath through cmd_type and reads status_type.
`timescale 1ns / 1ps

module tola_ctrl #(
   parameter int MAX_REQUESTERS = tola_pkg::DEF_MAX_REQUESTERS,
   parameter int IDX_BITS       = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   csr_we,
   input  logic [3:0]             csr_data,
   output tola_pkg::cmd_type      cmd,
   output logic [IDX_BITS-1:0]    rd_idx,
   input  tola_pkg::status_type   status
);
   import tola_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_REQUESTERS + 1);

   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]  limit_ff, limit_in;
   logic [3:0]           active_count_ff, active_count_in;
   logic [31:0]          count_wide;
   logic                 scan_more;

   assign count_wide = 32'(active_count_ff);
   assign scan_more  = (cnt_ff < limit_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!status.in_range || !scan_more) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = 1'b1;
      cmd.accept = 1'b0;
      cmd.rd_en  = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_SCAN: begin
            cmd.rd_en = scan_more;
         end
         ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

   assign rd_idx = cnt_ff[IDX_BITS-1:0];

   always_comb begin
      cnt_in          = cnt_ff;
      limit_in        = limit_ff;
      active_count_in = active_count_ff;
      if (csr_we) active_count_in = csr_data;
      if (cmd.accept) begin
         cnt_in = '0;
         // active count above the requester count scans all requesters
         if (count_wide > 32'(MAX_REQUESTERS)) limit_in = CNT_BITS'(MAX_REQUESTERS);
         else limit_in = CNT_BITS'(count_wide);
      end else if (cmd.rd_en) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         limit_ff        <= '0;
         active_count_ff <= ACTIVE_COUNT_RESET;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         limit_ff        <= limit_in;
         active_count_ff <= active_count_in;
      end
   end

endmodule

[rtl/tola_dpath.sv]
// Datapath of the arbiter: ticket memory, interested flags, shared comparator,
// scan accumulators and the result register. Depends on tola_pkg.
`timescale 1ns / 1ps

module tola_dpath #(
   parameter int MAX_REQUESTERS = tola_pkg::DEF_MAX_REQUESTERS,
   parameter int TICKET_BITS    = tola_pkg::DEF_TICKET_BITS,
   parameter int IDX_BITS       = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tola_pkg::cmd_type      cmd,
   input  logic [IDX_BITS-1:0]    rd_idx,
   input  tola_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tola_pkg::rsp_type      rsp_data,
   output tola_pkg::status_type   status
);
   import tola_pkg::*;

   localparam logic [TICKET_BITS-1:0] TICKET_MAX = {TICKET_BITS{1'b1}};

   logic [TICKET_BITS-1:0]    mem [MAX_REQUESTERS];
   logic [MAX_REQUESTERS-1:0] filled_ff, filled_in;
   logic [MAX_REQUESTERS-1:0] interested_ff, interested_in;

   logic [1:0]             action_ff;
   logic [IDX_BITS-1:0]    me_ff;
   logic                   in_range_ff;
   logic [TICKET_BITS-1:0] me_ticket_ff;
   logic [TICKET_BITS-1:0] rd_data_ff;
   logic                   proc_ff;
   logic [IDX_BITS-1:0]    proc_idx_ff;
   logic [TICKET_BITS-1:0] top_ff, top_in;
   logic                   blocked_ff, blocked_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff;

   logic [31:0]            req_wide;
   logic                   req_in_range;
   logic [IDX_BITS-1:0]    req_idx;
   logic [TICKET_BITS-1:0] cmp_a, cmp_b;
   logic                   cmp_lt, cmp_eq, precedes;
   logic [TICKET_BITS-1:0] next_ticket;
   rsp_type                result;

   function automatic logic [31:0] low_word(input logic [TICKET_BITS-1:0] t);
      logic [63:0] w;
      w = 64'(t);
      return w[31:0];
   endfunction

   assign req_wide     = 32'(req_data.requester);
   assign req_in_range = (req_wide < 32'(MAX_REQUESTERS));
   assign req_idx      = req_wide[IDX_BITS-1:0];

   // one comparator: max search for a request, (ticket, id) order for a poll
   always_comb begin
      if (action_ff == ACT_REQUEST) begin
         cmp_a = top_ff;
         cmp_b = rd_data_ff;
      end else begin
         cmp_a = rd_data_ff;
         cmp_b = me_ticket_ff;
      end
   end
   assign cmp_lt   = (cmp_a < cmp_b);
   assign cmp_eq   = (cmp_a == cmp_b);
   assign precedes = cmp_lt || (cmp_eq && (proc_idx_ff < me_ff));

   always_comb begin
      top_in     = top_ff;
      blocked_in = blocked_ff;
      if (cmd.accept) begin
         top_in     = '0;
         blocked_in = 1'b0;
      end else if (proc_ff) begin
         if (action_ff == ACT_REQUEST) begin
            if (cmp_lt) top_in = rd_data_ff;
         end else if (interested_ff[proc_idx_ff] && (proc_idx_ff != me_ff) && precedes) begin
            blocked_in = 1'b1;
         end
      end
   end

   assign next_ticket = (top_ff == TICKET_MAX) ? TICKET_MAX : top_ff + TICKET_BITS'(1);

   always_comb begin
      result.granted          = 1'b0;
      result.ticket           = low_word(me_ticket_ff);
      result.ticket_saturated = 1'b0;
      case (action_ff)
         ACT_REQUEST: begin
            result.ticket           = low_word(next_ticket);
            result.ticket_saturated = (next_ticket == TICKET_MAX);
         end
         ACT_POLL: begin
            result.granted = interested_ff[me_ff] && !blocked_ff;
         end
         default: result.granted = 1'b0;
      endcase
      // requester beyond the array leaves everything at zero
      if (!in_range_ff) begin
         result = '0;
      end
   end

   always_comb begin
      filled_in     = filled_ff;
      interested_in = interested_ff;
      if (cmd.finish && in_range_ff) begin
         if (action_ff == ACT_REQUEST) begin
            filled_in[me_ff]     = 1'b1;
            interested_in[me_ff] = 1'b1;
         end else if (action_ff == ACT_RELEASE) begin
            interested_in[me_ff] = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   // ticket memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.finish && in_range_ff && (action_ff == ACT_REQUEST)) begin
         mem[me_ff] <= next_ticket;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= filled_ff[rd_idx] ? mem[rd_idx] : '0;
      end
      if (cmd.accept) begin
         if (req_in_range && filled_ff[req_idx]) me_ticket_ff <= mem[req_idx];
         else me_ticket_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff   <= req_data.action;
         me_ff       <= req_idx;
         in_range_ff <= req_in_range;
      end
      proc_idx_ff <= rd_idx;
      top_ff      <= top_in;
      blocked_ff  <= blocked_in;
      if (cmd.finish) rsp_ff <= result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff     <= '0;
         interested_ff <= '0;
         proc_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         filled_ff     <= filled_in;
         interested_ff <= interested_in;
         proc_ff       <= cmd.rd_en;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.in_range = in_range_ff;

endmodule
